FILE: src/bls_pkg.sv
// Package for the box line sum convolver: FSM states, register indexes,
// sample format codes and the sample reduction function. No dependencies.
`timescale 1ns / 1ps

package bls_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MAC,
    ST_DIVGO,
    ST_DIV,
    ST_DONE
  } state_e;

  localparam logic [2:0] REG_LINE_INDEX    = 3'd0;
  localparam logic [2:0] REG_LINE_START    = 3'd1;
  localparam logic [2:0] REG_LINE_END      = 3'd2;
  localparam logic [2:0] REG_LINE_WEIGHT   = 3'd3;
  localparam logic [2:0] REG_LINE_COUNT    = 3'd4;
  localparam logic [2:0] REG_AREA          = 3'd5;
  localparam logic [2:0] REG_ROUNDING      = 3'd6;
  localparam logic [2:0] REG_SAMPLE_FORMAT = 3'd7;

  localparam logic [2:0] FMT_UCHAR  = 3'd0;
  localparam logic [2:0] FMT_SCHAR  = 3'd1;
  localparam logic [2:0] FMT_USHORT = 3'd2;
  localparam logic [2:0] FMT_SHORT  = 3'd3;

  function automatic logic signed [31:0] reduce_sample(input logic [31:0] raw,
                                                       input logic [2:0]  fmt);
    logic signed [31:0] r;
    case (fmt)
      FMT_UCHAR:  r = {24'd0, raw[7:0]};
      FMT_SCHAR:  r = {{24{raw[7]}}, raw[7:0]};
      FMT_USHORT: r = {16'd0, raw[15:0]};
      FMT_SHORT:  r = {{16{raw[15]}}, raw[15:0]};
      default:    r = raw;
    endcase
    return r;
  endfunction

endpackage

FILE: src/bls_lane.sv
// One line accumulator cell: adds the window sample passing by when its
// position lies in [start, end). Depends on bls_pkg.
`timescale 1ns / 1ps

module bls_lane import bls_pkg::*; #(
  parameter int PW = 6,
  parameter int SW = 38
) (
  input  logic                 clk_i,
  input  logic                 clear_i,
  input  logic                 step_i,
  input  logic signed [31:0]   sample_i,
  input  logic [PW-1:0]        pos_i,
  input  logic [6:0]           start_i,
  input  logic [6:0]           end_i,
  output logic signed [SW-1:0] sum_o
);

  localparam int CW = (PW + 1 > 7) ? PW + 1 : 7;

  logic signed [SW-1:0] sum_q, sum_d;
  logic [CW-1:0]        pos_w, st_w, en_w;
  logic                 hit;

  assign pos_w = CW'(pos_i);
  assign st_w  = CW'(start_i);
  assign en_w  = CW'(end_i);
  assign hit   = (st_w <= pos_w) && (pos_w < en_w);

  always_comb begin
    sum_d = sum_q;
    if (clear_i) begin
      sum_d = '0;
    end else if (step_i && hit) begin
      sum_d = sum_q + {{(SW-32){sample_i[31]}}, sample_i};
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

FILE: src/bls_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, unsigned.
// Depends on bls_pkg.
`timescale 1ns / 1ps

module bls_div import bls_pkg::*; #(
  parameter int DW = 53
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [30:0]   divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CNW = $clog2(DW + 1);

  logic [31:0]    rem_q, rem_d;
  logic [DW-1:0]  quo_q, quo_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic [31:0]    trial;
  logic           fits;

  assign trial = {rem_q[30:0], quo_q[DW-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = CNW'(DW);
    end else if (cnt_q != '0) begin
      rem_d = fits ? trial - {1'b0, divisor_i} : trial;
      quo_d = {quo_q[DW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

endmodule

FILE: src/box_line_sum_convolver.sv
// Box line sum convolver top level: sample window chain, line lanes,
// weight MAC, divider and clip. Depends on bls_pkg, bls_lane, bls_div.
`timescale 1ns / 1ps
//
// Usage:
//   s_axis_*: one sample per item; tdata = sample, tuser = row_start.
//   m_axis_*: one filtered result per item once WINDOW samples of the
//   current row are held; tdata = filtered.
//   cfg_*: register writes (index 0..7), always ready; write only when idle.
// Sequence:
//   An item that leaves the window short of full yields no result. An item
//   with a full window is processed in turn: the window rotates once through
//   the cell chain with all lanes summing in parallel, one MAC per line, then
//   the divider yields one quotient bit per cycle.
// Reset: clears the fill count, line table and registers (area = 1).
// Stall: a result waits in the output register; the next item is taken
//   meanwhile, and its own result holds in the last step until taken.
//
module box_line_sum_convolver import bls_pkg::*; #(
  parameter int WINDOW = 64,
  parameter int LINES  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample
  input  logic        s_axis_tuser,   // [0] row_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] filtered
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int PW   = $clog2(WINDOW);
  localparam int FCW  = PW + 1;
  localparam int SW   = 32 + PW;
  localparam int PRW  = SW + 9;
  localparam int AW   = PRW + $clog2(LINES + 1) + 1;
  localparam int LCW  = $clog2(LINES + 1);

  state_e state_q, state_d;

  // configuration
  logic [3:0]         line_index_q;
  logic [4:0]         line_count_q;
  logic [30:0]        area_q;
  logic signed [31:0] rounding_q;
  logic [2:0]         format_q;
  logic [6:0]         start_q  [LINES];
  logic [6:0]         end_q    [LINES];
  logic signed [8:0]  weight_q [LINES];

  logic cfg_we;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_index_q <= '0;
      line_count_q <= '0;
      area_q       <= 31'd1;
      rounding_q   <= '0;
      format_q     <= '0;
      for (int i = 0; i < LINES; i++) begin
        start_q[i]  <= '0;
        end_q[i]    <= '0;
        weight_q[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_LINE_INDEX:    line_index_q <= cfg_data_i[3:0];
        REG_LINE_COUNT:    line_count_q <= cfg_data_i[4:0];
        REG_AREA:          area_q       <= cfg_data_i[30:0];
        REG_ROUNDING:      rounding_q   <= cfg_data_i;
        REG_SAMPLE_FORMAT: format_q     <= cfg_data_i[2:0];
        default: begin
          for (int i = 0; i < LINES; i++) begin
            if (32'(line_index_q) == i) begin
              if (cfg_index_i == REG_LINE_START)  start_q[i]  <= cfg_data_i[6:0];
              if (cfg_index_i == REG_LINE_END)    end_q[i]    <= cfg_data_i[6:0];
              if (cfg_index_i == REG_LINE_WEIGHT) weight_q[i] <= cfg_data_i[8:0];
            end
          end
        end
      endcase
    end
  end

  // window cell chain: shift in on accept, rotate during scan
  logic signed [31:0] win_q [WINDOW];
  logic               in_acc;
  logic               scan_step;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign scan_step = state_q == ST_SCAN;

  always_ff @(posedge clk_i) begin
    if (in_acc || scan_step) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WINDOW-1] <= in_acc ? reduce_sample(s_axis_tdata, format_q) : win_q[0];
    end
  end

  // fill count and scan position
  logic [FCW-1:0] fill_q, fill_d, fill_base;
  logic [PW-1:0]  pos_q, pos_d;

  always_comb begin
    fill_base = s_axis_tuser ? '0 : fill_q;
    fill_d    = fill_q;
    if (in_acc) begin
      fill_d = (fill_base < FCW'(WINDOW)) ? fill_base + 1'b1 : fill_base;
    end
  end

  // line lanes
  logic signed [SW-1:0] sums [LINES];
  logic                 lane_clear;
  assign lane_clear = in_acc;

  for (genvar g = 0; g < LINES; g++) begin : g_lane
    bls_lane #(.PW(PW), .SW(SW)) u_lane (
      .clk_i    (clk_i),
      .clear_i  (lane_clear),
      .step_i   (scan_step),
      .sample_i (win_q[0]),
      .pos_i    (pos_q),
      .start_i  (start_q[g]),
      .end_i    (end_q[g]),
      .sum_o    (sums[g])
    );
  end

  // weight MAC
  logic [LCW-1:0]        z_q, z_d;
  logic signed [SW-1:0]  sel_s;
  logic signed [8:0]     sel_w;
  logic signed [PRW-1:0] prod, prod_q, prod_d;
  logic signed [AW-1:0]  acc_q, acc_d;
  logic [31:0]           eff_n;

  assign eff_n = (32'(line_count_q) > LINES) ? LINES : 32'(line_count_q);

  always_comb begin
    sel_s = '0;
    sel_w = '0;
    for (int i = 0; i < LINES; i++) begin
      if (LCW'(i) == z_q) begin
        sel_s = sums[i];
        sel_w = weight_q[i];
      end
    end
  end

  assign prod = sel_s * sel_w;

  // divider
  logic [AW-1:0] mag;
  logic          neg_q, neg_d;
  logic          div_start, div_busy;
  logic [AW-1:0] quot;
  logic [30:0]   divisor;

  assign mag       = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
  assign divisor   = (area_q == '0) ? 31'd1 : area_q;
  assign div_start = state_q == ST_DIVGO;

  bls_div #(.DW(AW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  // sign and clip
  logic signed [AW:0] q_s, lo, hi, clipped;

  always_comb begin
    q_s = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    case (format_q)
      FMT_UCHAR:  begin lo = '0;               hi = (AW+1)'(255);   end
      FMT_SCHAR:  begin lo = -(AW+1)'(128);    hi = (AW+1)'(127);   end
      FMT_USHORT: begin lo = '0;               hi = (AW+1)'(65535); end
      FMT_SHORT:  begin lo = -(AW+1)'(32768);  hi = (AW+1)'(32767); end
      default: begin
        lo = (AW+1)'($signed(32'h8000_0000));
        hi = (AW+1)'($signed(32'h7fff_ffff));
      end
    endcase
    if (q_s < lo) begin
      clipped = lo;
    end else if (q_s > hi) begin
      clipped = hi;
    end else begin
      clipped = q_s;
    end
  end

  // output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q;
  logic        out_load;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc && fill_d == FCW'(WINDOW)) state_d = ST_SCAN;
      ST_SCAN:  if (pos_q == PW'(WINDOW - 1)) state_d = ST_MAC;
      ST_MAC:   if (z_q == LCW'(LINES)) state_d = ST_DIVGO;
      ST_DIVGO: state_d = ST_DIV;
      ST_DIV:   if (!div_busy) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    s_axis_tready = state_q == ST_IDLE;
    out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
    pos_d         = pos_q;
    z_d           = z_q;
    acc_d         = acc_q;
    prod_d        = prod_q;
    neg_d         = neg_q;
    case (state_q)
      ST_IDLE: begin
        pos_d  = '0;
        z_d    = '0;
        prod_d = '0;
        acc_d  = AW'(rounding_q);
      end
      ST_SCAN: begin
        pos_d = pos_q + 1'b1;
      end
      ST_MAC: begin
        acc_d  = acc_q + AW'(prod_q);
        prod_d = (32'(z_q) < eff_n) ? prod : '0;
        z_d    = z_q + 1'b1;
      end
      ST_DIVGO: begin
        neg_d = acc_q[AW-1];
      end
      default: ;
    endcase
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    z_q    <= z_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
    if (out_load) out_data_q <= clipped[31:0];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: verif/box_line_sum_convolver_tb.sv
// Self-checking testbench for box_line_sum_convolver: directed table of runs,
// then random rows under random line setups. Depends on bls_pkg and the RTL.
`timescale 1ns / 1ps

module box_line_sum_convolver_tb;
  import bls_pkg::*;

  localparam int WIN    = 64;
  localparam int NLINES = 16;
  localparam int SETTLE = 160;   // cycles that cover one full-window item

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] sample
  logic        s_axis_tuser = 1'b0; // [0] row_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] filtered
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  box_line_sum_convolver u_top (.*);

  always #5 clk_i = ~clk_i;

  // Shadow of the block: registers, line table, sample window.
  logic [3:0]         sel_line;
  logic [4:0]         used_lines;
  logic [30:0]        norm_area;
  logic signed [31:0] bias;
  logic [2:0]         fmt;
  logic [6:0]         ln_start [NLINES];
  logic [6:0]         ln_end   [NLINES];
  logic signed [8:0]  ln_wt    [NLINES];
  logic signed [31:0] win_hist [WIN];
  int                 held;

  logic [31:0] filtered_q[$];
  int  err_cnt, items_sent, results_seen, phases_run;
  bit  quiet;
  int  rx_hold_cycles;

  function automatic void shadow_write(logic [2:0] idx, logic [31:0] d);
    case (idx)
      REG_LINE_INDEX:    sel_line = d[3:0];
      REG_LINE_START:    ln_start[sel_line] = d[6:0];
      REG_LINE_END:      ln_end[sel_line] = d[6:0];
      REG_LINE_WEIGHT:   ln_wt[sel_line] = d[8:0];
      REG_LINE_COUNT:    used_lines = d[4:0];
      REG_AREA:          norm_area = d[30:0];
      REG_ROUNDING:      bias = d;
      REG_SAMPLE_FORMAT: fmt = d[2:0];
      default: ;
    endcase
  endfunction

  // Advance the window by one sample; return 1 with the filtered value once full.
  function automatic bit filter_step(logic [31:0] raw, logic rs, output logic [31:0] res);
    logic signed [31:0] s;
    longint acc, sum, div, q, lo, hi;
    int n, en;
    case (fmt)
      FMT_UCHAR:  s = {24'd0, raw[7:0]};
      FMT_SCHAR:  s = {{24{raw[7]}}, raw[7:0]};
      FMT_USHORT: s = {16'd0, raw[15:0]};
      FMT_SHORT:  s = {{16{raw[15]}}, raw[15:0]};
      default:    s = raw;
    endcase
    if (rs) held = 0;
    for (int i = 0; i < WIN - 1; i++) win_hist[i] = win_hist[i+1];
    win_hist[WIN-1] = s;
    if (held < WIN) held++;
    n = (used_lines > NLINES) ? NLINES : used_lines;
    acc = 0;
    for (int z = 0; z < n; z++) begin
      sum = 0;
      en = (ln_end[z] > WIN) ? WIN : ln_end[z];
      for (int p = ln_start[z]; p < en; p++) sum += win_hist[p];
      acc += longint'(ln_wt[z]) * sum;
    end
    res = '0;
    if (held < WIN) return 0;
    div = (norm_area == 0) ? 1 : longint'(norm_area);
    q = (acc + longint'(bias)) / div;
    case (fmt)
      FMT_UCHAR:  begin lo = 0;      hi = 255;   end
      FMT_SCHAR:  begin lo = -128;   hi = 127;   end
      FMT_USHORT: begin lo = 0;      hi = 65535; end
      FMT_SHORT:  begin lo = -32768; hi = 32767; end
      default:    begin lo = -64'sd2147483648; hi = 64'sd2147483647; end
    endcase
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    res = q[31:0];
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    err_cnt++;
  endtask

  // Leave cfg_valid_i high; cfg_release drops it after the last write.
  task automatic cfg_write(logic [2:0] idx, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    shadow_write(idx, d);
  endtask

  task automatic cfg_release();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop offering items, then wait for every expected result.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Send one item; typed selects a fixed expectation in place of the shadow's.
  task automatic send_item(logic [31:0] d, logic rs, bit typed, logic [31:0] want);
    int gap;
    logic [31:0] r;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= rs;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
    if (filter_step(d, rs, r)) filtered_q.push_back(typed ? want : r);
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] noisy(logic [31:0] v, int w);
    logic [31:0] m;
    m = (32'h1 << w) - 1;
    return ($urandom & ~m) | (v & m);
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 15))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stall per result, one long hold-off on request.
  initial begin
    logic [31:0] got;
    int stall;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 8);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      @(negedge clk_i);
      while (!m_axis_tvalid) @(negedge clk_i);
      got = m_axis_tdata;
      @(posedge clk_i);
      results_seen++;
      if (filtered_q.size() == 0) report_mismatch("unexpected result", got, 'x);
      else begin
        logic [31:0] want;
        want = filtered_q.pop_front();
        if (got !== want) report_mismatch("filtered", got, want);
      end
    end
  end

  initial begin
    #30ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  typedef struct {
    logic [2:0]  fm;
    logic [31:0] d;
    logic        rs;
    int          cnt;
    bit          typed;
    logic [31:0] want;
  } run_t;

  // Entry 0 runs at reset settings; the rest after one full-window line of weight 1.
  run_t runs [] = '{
    '{3'd0,       32'hFFFF_FFFF, 1'b1, 64, 1'b1, 32'h0},
    '{3'd4,       32'h7FFF_FFFF, 1'b1, 64, 1'b1, 32'h7FFF_FFFF},
    '{3'd4,       32'h8000_0000, 1'b1, 64, 1'b1, 32'h8000_0000},
    '{FMT_UCHAR,  32'hFFFF_FFFF, 1'b1, 64, 1'b1, 32'd255},
    '{FMT_SCHAR,  32'h0000_0080, 1'b1, 64, 1'b1, 32'hFFFF_FF80},
    '{FMT_SCHAR,  32'hFFFF_FF7F, 1'b1, 64, 1'b1, 32'd127},
    '{FMT_USHORT, 32'hFFFF_FFFF, 1'b1, 64, 1'b1, 32'd65535},
    '{FMT_SHORT,  32'h0000_8000, 1'b1, 64, 1'b1, 32'hFFFF_8000},
    '{3'd7,       32'h0000_0001, 1'b1, 64, 1'b1, 32'd64},
    '{3'd4,       32'h0000_0005, 1'b1, 30, 1'b0, 32'h0},
    '{3'd4,       32'h0000_0005, 1'b1, 64, 1'b1, 32'd320},
    '{3'd4,       32'hA5A5_5A5A, 1'b0, 6,  1'b0, 32'h0},
    '{3'd4,       32'h0000_0002, 1'b1, 10, 1'b0, 32'h0}
  };

  initial begin
    int len, kind, budget;
    logic [6:0] st;
    sel_line = '0; used_lines = '0; norm_area = 31'd1; bias = '0; fmt = FMT_UCHAR; held = 0;
    for (int i = 0; i < NLINES; i++) begin
      ln_start[i] = '0; ln_end[i] = '0; ln_wt[i] = '0;
    end
    for (int i = 0; i < WIN; i++) win_hist[i] = '0;
    err_cnt = 0; items_sent = 0; results_seen = 0; phases_run = 0;
    quiet = 0; rx_hold_cycles = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (runs[k]) begin
      if (k == 1) begin
        drain();
        cfg_write(REG_LINE_INDEX, 32'd0);
        cfg_write(REG_LINE_START, 32'd0);
        cfg_write(REG_LINE_END, WIN);
        cfg_write(REG_LINE_WEIGHT, 32'd1);
        cfg_write(REG_LINE_COUNT, 32'd1);
        cfg_release();
      end
      if (k > 0 && runs[k].fm != fmt) begin
        drain();
        cfg_write(REG_SAMPLE_FORMAT, 32'(runs[k].fm));
        cfg_release();
      end
      for (int j = 0; j < runs[k].cnt; j++)
        send_item(runs[k].d, runs[k].rs && j == 0, runs[k].typed, runs[k].want);
    end

    for (int ph = 0; ph < 11; ph++) begin
      idle_input();
      drain();
      // Sweep the line table and the scalar registers; extremes on the edge phases.
      for (int i = 0; i < NLINES; i++) begin
        cfg_write(REG_LINE_INDEX, noisy(i, 4));
        st = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(0, 63));
        cfg_write(REG_LINE_START, noisy(32'(st), 7));
        cfg_write(REG_LINE_END, noisy(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                      : $urandom_range(st, 64), 7));
        cfg_write(REG_LINE_WEIGHT, (ph == 1) ? noisy(32'h101, 9) : $urandom);
      end
      cfg_write(REG_LINE_COUNT, (ph == 1) ? noisy(16, 5) : (ph == 2) ? noisy(31, 5) : $urandom);
      case (ph % 5)
        0: cfg_write(REG_AREA, noisy(0, 31));
        1: cfg_write(REG_AREA, 32'h7FFF_FFFF);
        2: cfg_write(REG_AREA, 32'd1);
        3: cfg_write(REG_AREA, $urandom_range(1, 4096));
        default: cfg_write(REG_AREA, $urandom);
      endcase
      case (ph % 4)
        0: cfg_write(REG_ROUNDING, 32'h8000_0000);
        1: cfg_write(REG_ROUNDING, 32'h7FFF_FFFF);
        2: cfg_write(REG_ROUNDING, $urandom_range(0, 2048));
        default: cfg_write(REG_ROUNDING, $urandom);
      endcase
      cfg_write(REG_SAMPLE_FORMAT, noisy(ph % 8, 3));
      cfg_release();
      phases_run++;
      quiet = (ph % 3 == 2);
      // Hold the receiver off while rows keep coming, so the input backs up.
      if (ph == 4) rx_hold_cycles = 1500;
      budget = (ph == 4) ? 20 : 2;
      while (budget > 0) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) len = $urandom_range(WIN, WIN + 26);
        else if (kind < 9) len = $urandom_range(1, WIN - 1);
        else len = $urandom_range(1, 10);
        for (int j = 0; j < len; j++)
          send_item(pick_sample(), (kind < 9) ? (j == 0) : 1'($urandom_range(0, 1)),
                    1'b0, 'x);
        budget -= (kind < 7) ? len - WIN + 1 : 1;
      end
      quiet = 0;
    end

    idle_input();
    drain();
    $display("covered %0d items, %0d results, %0d random line setups plus directed runs",
             items_sent, results_seen, phases_run);
    $display("mismatches: %0d", err_cnt);
    if (err_cnt == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
src/bls_pkg.sv
src/bls_lane.sv
src/bls_div.sv
src/box_line_sum_convolver.sv
verif/box_line_sum_convolver_tb.sv
